// ===== design/kkf_pkg.sv =====
// ----------------------------------------------------------------------------
// kkf_pkg
// Shared constants, types and helpers for the keyboard key FIFO device.
// ----------------------------------------------------------------------------
package kkf_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 16;
  localparam int KEY_SPACE           = 256;
  localparam int KEY_W               = $clog2(KEY_SPACE);
  localparam int DATA_W              = 16;

  // Event kinds carried by the mode field.
  localparam logic [1:0] MODE_PRESS   = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_COMMAND = 2'd2;

  // Command numbers carried in register A.
  localparam logic [DATA_W-1:0] CMD_CLEAR    = 16'd0;
  localparam logic [DATA_W-1:0] CMD_NEXT_KEY = 16'd1;
  localparam logic [DATA_W-1:0] CMD_KEY_TEST = 16'd2;
  localparam logic [DATA_W-1:0] CMD_SET_IRQ  = 16'd3;

  typedef struct packed {
    logic             push;
    logic             pop;
    logic             clear;
    logic [KEY_W-1:0] key;
  } queue_ctrl_t;

  typedef struct packed {
    logic             en;
    logic             down;
    logic [KEY_W-1:0] key;
  } map_upd_t;

  // Upper-case letters share their map entry with the lower-case letter.
  function automatic logic [KEY_W-1:0] fold_key(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] r;
    r = k;
    if (k inside {[8'h41:8'h5A]}) begin
      r = k + 8'h20;
    end
    return r;
  endfunction

endpackage

// ===== design/kkf_queue.sv =====
// ----------------------------------------------------------------------------
// kkf_queue
// Circular key FIFO with a synchronous read port for the popped word.
// ----------------------------------------------------------------------------
module kkf_queue #(
  parameter int QUEUE_DEPTH = kkf_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  kkf_pkg::queue_ctrl_t     ctrl,
  output logic                     empty,
  output logic [kkf_pkg::KEY_W-1:0] rd_key
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);

  logic [kkf_pkg::KEY_W-1:0] mem [QUEUE_DEPTH];
  logic [IDX_W-1:0] head;
  logic [CNT_W-1:0] count;
  logic [SUM_W-1:0] tail_sum;
  logic [SUM_W-1:0] tail_wrap;
  logic [IDX_W-1:0] tail;
  logic             full;
  logic             do_push;
  logic             do_pop;

  assign empty = (count == '0);
  assign full  = (count == DEPTH_CNT);

  // Head and count stay below twice the depth, so one subtract wraps the tail.
  assign tail_sum  = SUM_W'(head) + SUM_W'(count);
  assign tail_wrap = (tail_sum >= DEPTH_SUM) ? (tail_sum - DEPTH_SUM) : tail_sum;
  assign tail      = tail_wrap[IDX_W-1:0];

  assign do_push = ctrl.push && !full;
  assign do_pop  = ctrl.pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (ctrl.clear) begin
      head  <= '0;
      count <= '0;
    end else if (do_push) begin
      count <= count + CNT_W'(1);
    end else if (do_pop) begin
      head  <= (head == LAST_IDX) ? '0 : head + IDX_W'(1);
      count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail] <= ctrl.key;
    end
    if (do_pop) begin
      rd_key <= mem[head];
    end
  end

endmodule

// ===== design/kkf_keymap.sv =====
// ----------------------------------------------------------------------------
// kkf_keymap
// Key-down map held in a one-bit memory, cleared one entry per cycle after
// reset, with a registered read port for the key test.
// ----------------------------------------------------------------------------
module kkf_keymap (
  input  logic                      clk,
  input  logic                      rst,
  input  kkf_pkg::map_upd_t         upd,
  input  logic                      rd_en,
  input  logic [kkf_pkg::KEY_W-1:0] rd_key,
  output logic                      rd_down,
  output logic                      busy
);

  localparam int KW = kkf_pkg::KEY_W;
  localparam logic [KW-1:0] LAST_KEY = KW'(kkf_pkg::KEY_SPACE - 1);

  logic          mem [kkf_pkg::KEY_SPACE];
  logic          clearing;
  logic [KW-1:0] clear_idx;
  logic [KW-1:0] upd_idx;
  logic [KW-1:0] rd_idx;

  assign upd_idx = kkf_pkg::fold_key(upd.key);
  assign rd_idx  = kkf_pkg::fold_key(rd_key);
  assign busy    = clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clear_idx <= '0;
    end else if (clearing) begin
      clear_idx <= clear_idx + KW'(1);
      if (clear_idx == LAST_KEY) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clear_idx] <= 1'b0;
    end else if (upd.en) begin
      mem[upd_idx] <= upd.down;
    end
  end

  // An update landing at the same edge as the read is passed straight through.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_down <= (upd.en && (upd_idx == rd_idx)) ? upd.down : mem[rd_idx];
    end
  end

endmodule

// ===== design/keyboard_key_fifo_device.sv =====
// ----------------------------------------------------------------------------
// keyboard_key_fifo_device
// Keyboard device: key FIFO, key-down map and interrupt message register.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid / req_stall) carries one word per event:
//   a key press, a key release or a CPU command access. The response
//   channel (rsp_valid / rsp_stall) returns exactly one word per request,
//   in order, with the register C write and the interrupt, if any.
//   An accepted request sits in the input register and is processed into
//   the result register, raising rsp_valid, once that register may advance.
//   One request is taken every cycle while the response side keeps up and
//   the key-down map is not clearing; the FIFO and the message register each
//   take one access per cycle, the map one update and one read.
//   When rsp_stall is high the result register holds its word, the input
//   register fills, and req_stall rises until the response is taken.
//   Reset empties the FIFO, disables interrupts and drops both pipeline
//   registers. The key-down map is then cleared one entry per cycle, and
//   req_stall stays high until all 256 entries are cleared.
// ----------------------------------------------------------------------------
module keyboard_key_fifo_device #(
  parameter int QUEUE_DEPTH = kkf_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  mode,
  input  logic [7:0]  key_word,
  input  logic [15:0] cmd_a,
  input  logic [15:0] cmd_b,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic        c_write,
  output logic [15:0] c_value,
  output logic        irq_valid,
  output logic [15:0] irq_message
);

  localparam int KW = kkf_pkg::KEY_W;
  localparam int DW = kkf_pkg::DATA_W;

  // Input register.
  logic          pend_valid;
  logic [1:0]    pend_mode;
  logic [KW-1:0] pend_key;
  logic [DW-1:0] pend_a;
  logic [DW-1:0] pend_b;

  // Result register.
  logic          res_c_write;
  logic          res_from_queue;
  logic          res_flag;
  logic          res_irq;
  logic [DW-1:0] res_irq_msg;

  logic [DW-1:0] irq_msg;
  logic          advance;
  logic          take;
  logic          in_take;
  logic          is_press;
  logic          is_release;
  logic          is_event;
  logic          is_cmd;
  logic          key_in_range;
  logic          queue_empty;
  logic [KW-1:0] queue_key;
  logic          test_down;
  logic          map_busy;

  kkf_pkg::queue_ctrl_t qctrl;
  kkf_pkg::map_upd_t    mupd;

  assign advance   = !rsp_valid || !rsp_stall;
  assign take      = pend_valid && advance;
  assign req_stall = (pend_valid && !advance) || map_busy;
  assign in_take   = req_valid && !req_stall;

  assign is_press     = (pend_mode == kkf_pkg::MODE_PRESS);
  assign is_release   = (pend_mode == kkf_pkg::MODE_RELEASE);
  assign is_event     = is_press || is_release;
  assign is_cmd       = (pend_mode == kkf_pkg::MODE_COMMAND);
  assign key_in_range = (pend_b[DW-1:KW] == '0);

  assign qctrl.push  = take && is_press;
  assign qctrl.pop   = take && is_cmd && (pend_a == kkf_pkg::CMD_NEXT_KEY);
  assign qctrl.clear = take && is_cmd && (pend_a == kkf_pkg::CMD_CLEAR);
  assign qctrl.key   = pend_key;

  assign mupd.en   = take && is_event;
  assign mupd.down = is_press;
  assign mupd.key  = pend_key;

  kkf_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (qctrl),
    .empty (queue_empty),
    .rd_key(queue_key)
  );

  // The key-down bit is read as the request enters the input register.
  kkf_keymap u_keymap (
    .clk    (clk),
    .rst    (rst),
    .upd    (mupd),
    .rd_en  (in_take),
    .rd_key (cmd_b[KW-1:0]),
    .rd_down(test_down),
    .busy   (map_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (!req_stall) begin
      pend_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      pend_mode <= mode;
      pend_key  <= key_word;
      pend_a    <= cmd_a;
      pend_b    <= cmd_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      irq_msg <= '0;
    end else if (take && is_cmd && (pend_a == kkf_pkg::CMD_SET_IRQ)) begin
      irq_msg <= pend_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= pend_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_c_write    <= is_cmd && ((pend_a == kkf_pkg::CMD_NEXT_KEY) ||
                                   (pend_a == kkf_pkg::CMD_KEY_TEST));
      res_from_queue <= qctrl.pop && !queue_empty;
      res_flag       <= is_cmd && (pend_a == kkf_pkg::CMD_KEY_TEST) &&
                        key_in_range && test_down;
      res_irq        <= is_event && (irq_msg != '0);
      res_irq_msg    <= is_event ? irq_msg : '0;
    end
  end

  // The popped word comes straight from the FIFO's read register.
  assign c_write     = res_c_write;
  assign c_value     = res_from_queue ? {{(DW-KW){1'b0}}, queue_key}
                                      : {{(DW-1){1'b0}}, res_flag};
  assign irq_valid   = res_irq;
  assign irq_message = res_irq_msg;

endmodule
